>>> hdl/escu_pkg.sv
// Shared types, constants and arithmetic helpers for the sensor compensation unit.
`default_nettype none
package escu_pkg;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 88;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 48;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam int PRE_STAGES  = 14;
    localparam int POST_STAGES = 4;
    localparam int DIV_STEPS   = 64;
    localparam int DEN_W       = 31;

    localparam logic signed [63:0] P_TFINE_OFS = 64'sd128000;
    localparam logic signed [63:0] H_TFINE_OFS = 64'sd76800;
    localparam logic signed [63:0] P_BIAS      = 64'sh0000_8000_0000_0000;
    localparam logic signed [16:0] P_SCALE     = 17'sd3125;
    localparam logic signed [63:0] H_ROUND     = 64'sd16384;
    localparam logic signed [63:0] H_OFS3      = 64'sd32768;
    localparam logic signed [63:0] H_OFS2      = 64'sd2097152;
    localparam logic signed [63:0] H_ROUND2    = 64'sd8192;
    localparam logic signed [63:0] HUM_MAX     = 64'sd419430400;
    localparam logic [20:0]        P_FULL      = 21'h10_0000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TEMP    = 3'd0,
        CFG_PRESS_A = 3'd1,
        CFG_PRESS_B = 3'd2,
        CFG_PRESS_C = 3'd3,
        CFG_HUM_A   = 3'd4,
        CFG_HUM_B   = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [19:0] adc_t;
        logic [19:0] adc_p;
        logic [15:0] adc_h;
    } raw_t;

    typedef struct packed {
        logic [15:0]        t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic [15:0]        p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
        logic [7:0]         h1;
        logic signed [15:0] h2;
        logic [7:0]         h3;
        logic signed [11:0] h4;
        logic signed [11:0] h5;
        logic signed [7:0]  h6;
    } coeff_t;

    typedef struct packed {
        logic [31:0] tc;
        logic [16:0] hum;
        logic        inv;
    } div_side_t;

    function automatic logic signed [63:0] smul32(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return a * b;
    endfunction

    function automatic logic signed [63:0] smul_lo(input logic signed [63:0] a,
                                                   input logic signed [16:0] b);
        return a * b;
    endfunction

    function automatic logic signed [63:0] smul_24x40(input logic signed [23:0] a,
                                                      input logic signed [39:0] b);
        return a * b;
    endfunction

endpackage
`default_nettype wire

>>> hdl/escu_front.sv
// Input stage: takes measurement transactions and splits them into raw fields.
`default_nettype none
module escu_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // raw_temperature[19:0], raw_pressure[39:20], raw_humidity[55:40]
    input  wire logic [escu_pkg::IN_DATA_W-1:0] s_tdata,
    output logic                                out_vld,
    output escu_pkg::raw_t                      out_data,
    input  wire logic                           out_rdy
);
    import escu_pkg::*;

    logic hold_vld_reg, hold_vld_next;
    raw_t hold_reg;
    logic s_acc;

    assign s_tready = !hold_vld_reg || out_rdy;
    assign s_acc    = s_tvalid && s_tready;

    always_comb begin
        hold_vld_next = hold_vld_reg;
        if (s_acc) begin
            hold_vld_next = 1'b1;
        end else if (out_rdy) begin
            hold_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_vld_reg <= 1'b0;
        end else begin
            hold_vld_reg <= hold_vld_next;
        end
        if (s_acc) begin
            hold_reg.adc_t <= s_tdata[19:0];
            hold_reg.adc_p <= s_tdata[39:20];
            hold_reg.adc_h <= s_tdata[55:40];
        end
    end

    assign out_vld  = hold_vld_reg;
    assign out_data = hold_reg;
endmodule
`default_nettype wire

>>> hdl/escu_fifo.sv
// Short queue between the input stage and the compensation datapath.
`default_nettype none
module escu_fifo (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     wr_vld,
    input  wire escu_pkg::raw_t wr_data,
    output logic          wr_rdy,
    output logic          rd_vld,
    output escu_pkg::raw_t rd_data,
    input  wire logic     rd_en
);
    import escu_pkg::*;

    raw_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0]  cnt_reg, cnt_next;
    logic                push, pop;

    assign wr_rdy  = cnt_reg != FIFO_CW'(FIFO_DEPTH);
    assign rd_vld  = cnt_reg != '0;
    assign rd_data = mem_reg[rd_ptr_reg];
    assign push    = wr_vld && wr_rdy;
    assign pop     = rd_en && rd_vld;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end
endmodule
`default_nettype wire

>>> hdl/escu_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage, signed fix-up.
`default_nettype none
module escu_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       ce,
    input  wire logic                       in_vld,
    input  wire logic [63:0]                in_num,
    input  wire logic [escu_pkg::DEN_W-1:0] in_den,
    input  wire logic                       in_neg,
    input  wire escu_pkg::div_side_t        in_side,
    output logic                            out_vld,
    output logic signed [63:0]              out_quo,
    output escu_pkg::div_side_t             out_side
);
    import escu_pkg::*;

    typedef struct packed {
        logic             vld;
        logic [DEN_W-1:0] rem;
        logic [63:0]      dvd;
        logic [DEN_W-1:0] den;
        logic             neg;
        div_side_t        side;
    } dv_t;

    function automatic dv_t div_step(input dv_t x);
        dv_t          y;
        logic [DEN_W:0] rsh;
        logic         ge;
        y   = x;
        rsh = {x.rem, x.dvd[63]};
        ge  = rsh >= {1'b0, x.den};
        y.rem = ge ? DEN_W'(rsh - {1'b0, x.den}) : rsh[DEN_W-1:0];
        y.dvd = {x.dvd[62:0], ge};
        return y;
    endfunction

    dv_t dv_reg  [1:DIV_STEPS];
    dv_t dv_next [1:DIV_STEPS];
    dv_t dv_in;

    logic             out_vld_reg;
    logic signed [63:0] out_quo_reg;
    div_side_t        out_side_reg;

    always_comb begin
        dv_in.vld  = in_vld;
        dv_in.rem  = '0;
        dv_in.dvd  = in_num;
        dv_in.den  = in_den;
        dv_in.neg  = in_neg;
        dv_in.side = in_side;
        dv_next[1] = div_step(dv_in);
        for (int k = 2; k <= DIV_STEPS; k++) begin
            dv_next[k] = div_step(dv_reg[k-1]);
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 1; k <= DIV_STEPS; k++) begin
            if (!aresetn) begin
                dv_reg[k].vld <= 1'b0;
            end else if (ce) begin
                dv_reg[k] <= dv_next[k];
            end
        end
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (ce) begin
            out_vld_reg  <= dv_reg[DIV_STEPS].vld;
            out_side_reg <= dv_reg[DIV_STEPS].side;
            out_quo_reg  <= dv_reg[DIV_STEPS].neg ? -$signed(dv_reg[DIV_STEPS].dvd)
                                                  : $signed(dv_reg[DIV_STEPS].dvd);
        end
    end

    assign out_vld  = out_vld_reg;
    assign out_quo  = out_quo_reg;
    assign out_side = out_side_reg;
endmodule
`default_nettype wire

>>> hdl/escu_back.sv
// Compensation datapath: temperature, pressure and humidity pipeline with output register.
`default_nettype none
module escu_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire escu_pkg::coeff_t                cf,
    input  wire logic                            in_vld,
    input  wire escu_pkg::raw_t                  in_data,
    output logic                                 in_rdy,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // temperature_centi[31:0], pressure_q24_8[63:32], humidity_q22_10[80:64], zero pad
    output logic [escu_pkg::OUT_DATA_W-1:0]      m_tdata,
    // pressure_invalid[0]
    output logic                                 m_tuser
);
    import escu_pkg::*;

    typedef struct packed {
        logic               vld;
        logic [19:0]        adc_t;
        logic [19:0]        adc_p;
        logic [15:0]        adc_h;
        logic signed [63:0] ta, dd, at2, db, tfine, pa, hv;
        logic signed [63:0] sq, ap5, ap2, h5v, vh6, vh3;
        logic signed [63:0] b1, c1, ah, x6, x3, bsum, asum, hb;
        logic signed [63:0] dprod, nm0, hb2, numer, hb3, hv2, dsq, hm;
        logic [31:0]        tc;
        logic [63:0]        pp0, pp1;
        logic signed [DEN_W-1:0] den;
        logic               inv, neg;
        logic [63:0]        magn;
        logic [DEN_W-1:0]   magd;
        logic [16:0]        hum;
    } pre_t;

    typedef struct packed {
        logic               vld;
        logic signed [63:0] p, b8, ss, m9;
        logic [63:0]        pp0, pp1;
        logic [31:0]        pres;
        div_side_t          side;
    } post_t;

    function automatic logic [16:0] pr_next_src_t(input raw_t r);
        return r.adc_t[19:3];
    endfunction

    pre_t  pr_reg  [1:PRE_STAGES];
    pre_t  pr_next [1:PRE_STAGES];
    post_t q_reg   [1:POST_STAGES];
    post_t q_next  [1:POST_STAGES];

    logic               ce;
    div_side_t          dv_side_in, dv_side_out;
    logic               dv_vld_out;
    logic signed [63:0] dv_quo;

    assign ce     = !q_reg[POST_STAGES].vld || m_tready;
    assign in_rdy = ce;

    always_comb begin
        logic signed [18:0] at_s;
        logic signed [17:0] d_s;
        logic signed [63:0] hnum, dh, hv3, hvc;
        logic [20:0]        pn;

        at_s = $signed({2'b00, pr_next_src_t(in_data)}) - $signed({2'b00, cf.t1, 1'b0});
        d_s  = $signed({2'b00, in_data.adc_t[19:4]}) - $signed({2'b00, cf.t1});

        pr_next[1]       = '0;
        pr_next[1].vld   = in_vld;
        pr_next[1].adc_t = in_data.adc_t;
        pr_next[1].adc_p = in_data.adc_p;
        pr_next[1].adc_h = in_data.adc_h;
        pr_next[1].ta    = smul32(32'(at_s), 32'(cf.t2));
        pr_next[1].dd    = smul32(32'(d_s), 32'(d_s));

        pr_next[2]     = pr_reg[1];
        pr_next[2].at2 = pr_reg[1].ta >>> 11;
        pr_next[2].db  = smul32(32'(pr_reg[1].dd >>> 12), 32'(cf.t3));

        pr_next[3]       = pr_reg[2];
        pr_next[3].tfine = pr_reg[2].at2 + (pr_reg[2].db >>> 14);

        pr_next[4]    = pr_reg[3];
        pr_next[4].tc = 32'((pr_reg[3].tfine * 64'sd5 + 64'sd128) >>> 8);
        pr_next[4].pa = pr_reg[3].tfine - P_TFINE_OFS;
        pr_next[4].hv = pr_reg[3].tfine - H_TFINE_OFS;

        pr_next[5]     = pr_reg[4];
        pr_next[5].sq  = smul32(32'(pr_reg[4].pa), 32'(pr_reg[4].pa));
        pr_next[5].ap5 = smul32(32'(pr_reg[4].pa), 32'(cf.p5));
        pr_next[5].ap2 = smul32(32'(pr_reg[4].pa), 32'(cf.p2));
        pr_next[5].h5v = smul32(32'(cf.h5), 32'(pr_reg[4].hv));
        pr_next[5].vh6 = smul32(32'(pr_reg[4].hv), 32'(cf.h6));
        pr_next[5].vh3 = smul32(32'(pr_reg[4].hv), $signed({24'd0, cf.h3}));

        hnum = $signed({34'd0, pr_reg[5].adc_h, 14'd0})
             - $signed({{32{cf.h4[11]}}, cf.h4, 20'd0})
             - pr_reg[5].h5v + H_ROUND;
        pr_next[6]    = pr_reg[5];
        pr_next[6].b1 = smul_lo(pr_reg[5].sq, 17'(cf.p6));
        pr_next[6].c1 = smul_lo(pr_reg[5].sq, 17'(cf.p3));
        pr_next[6].ah = hnum >>> 15;
        pr_next[6].x6 = pr_reg[5].vh6 >>> 10;
        pr_next[6].x3 = (pr_reg[5].vh3 >>> 11) + H_OFS3;

        pr_next[7]      = pr_reg[6];
        pr_next[7].bsum = pr_reg[6].b1 + (pr_reg[6].ap5 <<< 17)
                        + $signed({{13{cf.p4[15]}}, cf.p4, 35'd0});
        pr_next[7].asum = (pr_reg[6].c1 >>> 8) + (pr_reg[6].ap2 <<< 12);
        pr_next[7].hb   = smul32(32'(pr_reg[6].x6), 32'(pr_reg[6].x3));

        pn = P_FULL - {1'b0, pr_reg[7].adc_p};
        pr_next[8]       = pr_reg[7];
        pr_next[8].dprod = smul_lo(pr_reg[7].asum + P_BIAS, $signed({1'b0, cf.p1}));
        pr_next[8].nm0   = $signed({12'd0, pn, 31'd0}) - pr_reg[7].bsum;
        pr_next[8].hb2   = (pr_reg[7].hb >>> 10) + H_OFS2;

        pr_next[9]       = pr_reg[8];
        pr_next[9].den   = $signed(pr_reg[8].dprod[63:33]);
        pr_next[9].numer = smul_lo(pr_reg[8].nm0, P_SCALE);
        pr_next[9].hb3   = smul_lo(pr_reg[8].hb2, 17'(cf.h2)) + H_ROUND2;

        pr_next[10]      = pr_reg[9];
        pr_next[10].inv  = pr_reg[9].den == '0;
        pr_next[10].neg  = pr_reg[9].numer[63] ^ pr_reg[9].den[DEN_W-1];
        pr_next[10].magn = pr_reg[9].numer[63] ? 64'(-pr_reg[9].numer)
                                               : 64'(pr_reg[9].numer);
        pr_next[10].magd = pr_reg[9].den[DEN_W-1] ? DEN_W'(-pr_reg[9].den)
                                                  : DEN_W'(pr_reg[9].den);
        pr_next[10].hv2  = smul_24x40(24'(pr_reg[9].ah), 40'(pr_reg[9].hb3 >>> 14));

        dh = pr_reg[10].hv2 >>> 15;
        pr_next[11]     = pr_reg[10];
        pr_next[11].pp0 = 64'(dh[31:0]) * 64'(dh[31:0]);
        pr_next[11].pp1 = 64'(dh[31:0]) * 64'(dh[63:32]);

        pr_next[12]     = pr_reg[11];
        pr_next[12].dsq = $signed(pr_reg[11].pp0 + (pr_reg[11].pp1 << 33));

        pr_next[13]    = pr_reg[12];
        pr_next[13].hm = smul_lo(pr_reg[12].dsq >>> 7, $signed({9'd0, cf.h1}));

        hv3 = pr_reg[13].hv2 - (pr_reg[13].hm >>> 4);
        if (hv3 < 0) begin
            hvc = '0;
        end else if (hv3 > HUM_MAX) begin
            hvc = HUM_MAX;
        end else begin
            hvc = hv3;
        end
        pr_next[14]     = pr_reg[13];
        pr_next[14].hum = hvc[28:12];
    end

    always_ff @(posedge aclk) begin
        for (int k = 1; k <= PRE_STAGES; k++) begin
            if (!aresetn) begin
                pr_reg[k].vld <= 1'b0;
            end else if (ce) begin
                pr_reg[k] <= pr_next[k];
            end
        end
    end

    assign dv_side_in.tc  = pr_reg[PRE_STAGES].tc;
    assign dv_side_in.hum = pr_reg[PRE_STAGES].hum;
    assign dv_side_in.inv = pr_reg[PRE_STAGES].inv;

    escu_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_vld   (pr_reg[PRE_STAGES].vld),
        .in_num   (pr_reg[PRE_STAGES].magn),
        .in_den   (pr_reg[PRE_STAGES].magd),
        .in_neg   (pr_reg[PRE_STAGES].neg),
        .in_side  (dv_side_in),
        .out_vld  (dv_vld_out),
        .out_quo  (dv_quo),
        .out_side (dv_side_out)
    );

    always_comb begin
        logic signed [63:0] s, sum, pr;

        s = dv_quo >>> 13;
        q_next[1]      = '0;
        q_next[1].vld  = dv_vld_out;
        q_next[1].side = dv_side_out;
        q_next[1].p    = dv_quo;
        q_next[1].pp0  = 64'(s[31:0]) * 64'(s[31:0]);
        q_next[1].pp1  = 64'(s[31:0]) * 64'(s[63:32]);
        q_next[1].b8   = smul_lo(dv_quo, 17'(cf.p8));

        q_next[2]    = q_reg[1];
        q_next[2].ss = $signed(q_reg[1].pp0 + (q_reg[1].pp1 << 33));

        q_next[3]    = q_reg[2];
        q_next[3].m9 = smul_lo(q_reg[2].ss, 17'(cf.p9));

        sum = q_reg[3].p + (q_reg[3].m9 >>> 25) + (q_reg[3].b8 >>> 19);
        pr  = (sum >>> 8) + $signed({{44{cf.p7[15]}}, cf.p7, 4'd0});
        q_next[4]      = q_reg[3];
        q_next[4].pres = q_reg[3].side.inv ? 32'd0 : pr[31:0];
    end

    always_ff @(posedge aclk) begin
        for (int k = 1; k <= POST_STAGES; k++) begin
            if (!aresetn) begin
                q_reg[k].vld <= 1'b0;
            end else if (ce) begin
                q_reg[k] <= q_next[k];
            end
        end
    end

    assign m_tvalid = q_reg[POST_STAGES].vld;
    assign m_tdata  = {7'd0, q_reg[POST_STAGES].side.hum, q_reg[POST_STAGES].pres,
                       q_reg[POST_STAGES].side.tc};
    assign m_tuser  = q_reg[POST_STAGES].side.inv;
endmodule
`default_nettype wire

>>> hdl/env_sensor_compensation_unit.sv
// Top level of the sensor compensation unit: coefficient registers and block wiring.
//
// Takes one raw temperature/pressure/humidity set per clock while the output is not
// stalled and returns the compensated temperature (0.01 degC), pressure (Q24.8 Pa,
// with a flag when the pressure divisor is zero) and humidity (Q22.10 %RH, clamped).
// Throughput is one set per cycle when the output is not stalled. A result passes the
// input register, the queue, 14 pre-divide stages, the one-bit-per-stage pressure
// divider with its output register and 4 post-divide stages. A stalled output freezes
// the compensation datapath, divider included. Coefficients must be written through
// the cfg port only while no transaction is in flight; the block does not enforce
// this. All coefficients reset to zero.
`default_nettype none
module env_sensor_compensation_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // raw_temperature[19:0], raw_pressure[39:20], raw_humidity[55:40]
    input  wire logic [escu_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // temperature_centi[31:0], pressure_q24_8[63:32], humidity_q22_10[80:64], zero pad
    output logic [escu_pkg::OUT_DATA_W-1:0]      m_tdata,
    // pressure_invalid[0]
    output logic                                 m_tuser,
    input  wire logic                            cfg_wr_en,
    input  wire logic [escu_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [escu_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import escu_pkg::*;

    logic [47:0] temp_reg, press_a_reg, press_b_reg, press_c_reg;
    logic [31:0] hum_a_reg, hum_b_reg;
    coeff_t      cf;

    logic fr_vld, fq_rdy, q_vld, bk_rdy;
    raw_t fr_data, q_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_reg    <= '0;
            press_a_reg <= '0;
            press_b_reg <= '0;
            press_c_reg <= '0;
            hum_a_reg   <= '0;
            hum_b_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_TEMP:    temp_reg    <= cfg_wr_data;
                CFG_PRESS_A: press_a_reg <= cfg_wr_data;
                CFG_PRESS_B: press_b_reg <= cfg_wr_data;
                CFG_PRESS_C: press_c_reg <= cfg_wr_data;
                CFG_HUM_A:   hum_a_reg   <= cfg_wr_data[31:0];
                CFG_HUM_B:   hum_b_reg   <= cfg_wr_data[31:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cf.t1 = temp_reg[15:0];
        cf.t2 = temp_reg[31:16];
        cf.t3 = temp_reg[47:32];
        cf.p1 = press_a_reg[15:0];
        cf.p2 = press_a_reg[31:16];
        cf.p3 = press_a_reg[47:32];
        cf.p4 = press_b_reg[15:0];
        cf.p5 = press_b_reg[31:16];
        cf.p6 = press_b_reg[47:32];
        cf.p7 = press_c_reg[15:0];
        cf.p8 = press_c_reg[31:16];
        cf.p9 = press_c_reg[47:32];
        cf.h1 = hum_a_reg[7:0];
        cf.h2 = hum_a_reg[23:8];
        cf.h3 = hum_a_reg[31:24];
        cf.h4 = hum_b_reg[11:0];
        cf.h5 = hum_b_reg[23:12];
        cf.h6 = hum_b_reg[31:24];
    end

    escu_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .out_vld  (fr_vld),
        .out_data (fr_data),
        .out_rdy  (fq_rdy)
    );

    escu_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_vld  (fr_vld),
        .wr_data (fr_data),
        .wr_rdy  (fq_rdy),
        .rd_vld  (q_vld),
        .rd_data (q_data),
        .rd_en   (bk_rdy)
    );

    escu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cf       (cf),
        .in_vld   (q_vld),
        .in_data  (q_data),
        .in_rdy   (bk_rdy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );
endmodule
`default_nettype wire
